/* rtl/stwss_pkg.sv */
// Package with shared constants, controller state type and control/status structs.
`timescale 1ns / 1ps
package stwss_pkg;

  localparam int STAGES_DEF = 9;
  localparam int WINDOW_DEF = 64;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_DISP    = 11'b00000000010,
    S_OLD_RD  = 11'b00000000100,
    S_OLD_GET = 11'b00000001000,
    S_RM_RD   = 11'b00000010000,
    S_RM_EV   = 11'b00000100000,
    S_INS_CHK = 11'b00001000000,
    S_INS_EV  = 11'b00010000000,
    S_Q_RD    = 11'b00100000000,
    S_Q_GET   = 11'b01000000000,
    S_DONE    = 11'b10000000000
  } state_t;

  typedef enum logic [1:0] {
    A_J   = 2'd0,
    A_JM1 = 2'd1,
    A_Q   = 2'd2
  } asel_t;

  typedef struct packed {
    logic  cap;
    logic  n_load;
    logic  commit;
    logic  take_old;
    logic  rm_ev;
    logic  j_inc;
    logic  j_dec;
    logic  q_take;
    logic  out_load;
    logic  r_we;
    logic  s_we;
    asel_t s_asel;
    logic  s_wsel_el;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic query;
    logic full;
    logic rm_last;
    logic j_zero;
    logic gt;
    logic found;
    logic empty;
    logic q_last;
    logic out_busy;
  } stat_t;

endpackage

/* rtl/stage_timing_window_stats_core.sv */
// Top level of the per-stage timing window statistics monitor.
// Flow: a query reads min, max and median of a non-empty stage from the sorted copy; a
// record first writes the ring, removes the oldest sample from the sorted list once the
// ring is full, inserts the new sample in order, and then reads the same three values.
// Items are handled one at a time: a new one is taken only after the last result is loaded,
// which output stalls can delay, and the single port of the sorted sample RAM serializes the work.
// Reset: rst is synchronous, active high; it empties every stage at once.
`timescale 1ns / 1ps
module stage_timing_window_stats_core import stwss_pkg::*; #(
  parameter int STAGES = STAGES_DEF,
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // stage[3:0], elapsed[35:4], zero pad
  input  logic         s_tuser,   // op
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [167:0] m_tdata,   // window_count, lifetime_count, last, min, max, median
  output logic         m_tuser    // stage_ok
);

  cmd_t   cmd;
  stat_t  st;
  logic [166:0] odata;

  stwss_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready), .st(st), .cmd(cmd)
  );

  stwss_dp #(.STAGES(STAGES), .WINDOW(WINDOW)) u_dp (
    .clk(clk), .rst(rst), .in_op(s_tuser), .in_data(s_tdata[35:0]),
    .out_ready(m_tready), .out_valid(m_tvalid), .out_ok(m_tuser), .out_data(odata),
    .cmd(cmd), .st(st)
  );

  assign m_tdata = {1'b0, odata};

endmodule

/* rtl/stwss_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module stwss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/stwss_ctrl.sv */
// Controller state machine that sequences record, sorted-list update and query.
`timescale 1ns / 1ps
module stwss_ctrl import stwss_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.s_asel = A_J;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (st.bad) begin
          state_next = S_DONE;
        end else if (st.query) begin
          state_next = S_Q_RD;
        end else begin
          cmd.n_load = 1'b1;
          if (st.full) begin
            state_next = S_OLD_RD;
          end else begin
            cmd.r_we = 1'b1;
            cmd.commit = 1'b1;
            state_next = S_INS_CHK;
          end
        end
      end
      S_OLD_RD: begin
        state_next = S_OLD_GET;
      end
      S_OLD_GET: begin
        cmd.take_old = 1'b1;
        cmd.r_we = 1'b1;
        cmd.commit = 1'b1;
        state_next = S_RM_RD;
      end
      S_RM_RD: begin
        state_next = S_RM_EV;
      end
      S_RM_EV: begin
        cmd.rm_ev = 1'b1;
        cmd.s_we = st.found;
        cmd.s_asel = A_JM1;
        if (st.rm_last) begin
          state_next = S_INS_CHK;
        end else begin
          cmd.j_inc = 1'b1;
          state_next = S_RM_RD;
        end
      end
      S_INS_CHK: begin
        if (st.j_zero) begin
          cmd.s_we = 1'b1;
          cmd.s_wsel_el = 1'b1;
          state_next = S_Q_RD;
        end else begin
          cmd.s_asel = A_JM1;
          state_next = S_INS_EV;
        end
      end
      S_INS_EV: begin
        cmd.s_we = 1'b1;
        if (st.gt) begin
          cmd.j_dec = 1'b1;
          state_next = S_INS_CHK;
        end else begin
          cmd.s_wsel_el = 1'b1;
          state_next = S_Q_RD;
        end
      end
      S_Q_RD: begin
        if (st.empty) begin
          state_next = S_DONE;
        end else begin
          cmd.s_asel = A_Q;
          state_next = S_Q_GET;
        end
      end
      S_Q_GET: begin
        cmd.q_take = 1'b1;
        if (st.q_last) begin
          state_next = S_DONE;
        end else begin
          state_next = S_Q_RD;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/stwss_dp.sv */
// Datapath with per-stage counters, the sample ring, the sorted copy and result register.
`timescale 1ns / 1ps
module stwss_dp import stwss_pkg::*; #(
  parameter int STAGES = STAGES_DEF,
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_op,
  input  logic [35:0]  in_data,
  input  logic         out_ready,
  output logic         out_valid,
  output logic         out_ok,
  output logic [166:0] out_data,
  input  cmd_t         cmd,
  output stat_t        st
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int WW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int D  = STAGES * WINDOW;
  localparam int AW = (D > 1) ? $clog2(D) : 1;

  logic          op_r;
  logic [3:0]    st_r;
  logic [31:0]   el_r;
  logic [31:0]   old_r;
  logic          found_r;
  logic [CW-1:0] n_r;
  logic [CW-1:0] j_r;
  logic [1:0]    qsel;
  logic [31:0]   mn_r, mx_r, md_r;

  logic [WW-1:0] wp    [STAGES];
  logic [CW-1:0] fill  [STAGES];
  logic [31:0]   total [STAGES];
  logic [31:0]   last  [STAGES];

  logic [SW-1:0] sidx;
  logic [CW-1:0] n_cur;
  logic [CW-1:0] jm1;
  logic [CW-1:0] qidx;
  logic [AW-1:0] base;
  logic [AW-1:0] r_addr, s_addr;
  logic [31:0]   r_rdata, s_rdata, s_wdata;
  logic [WW-1:0] s_idx;
  logic          ok, has;

  assign sidx  = st_r[SW-1:0];
  assign n_cur = fill[sidx];
  assign jm1   = j_r - CW'(1);
  assign base  = AW'(sidx) * AW'(WINDOW);

  always_comb begin
    case (qsel)
      2'd0:    qidx = '0;
      2'd1:    qidx = n_cur - CW'(1);
      default: qidx = n_cur >> 1;
    endcase
  end

  always_comb begin
    case (cmd.s_asel)
      A_J:     s_idx = j_r[WW-1:0];
      A_JM1:   s_idx = jm1[WW-1:0];
      A_Q:     s_idx = qidx[WW-1:0];
      default: s_idx = j_r[WW-1:0];
    endcase
  end

  assign s_addr  = base + AW'(s_idx);
  assign r_addr  = base + AW'(wp[sidx]);
  assign s_wdata = cmd.s_wsel_el ? el_r : s_rdata;

  stwss_ram #(.WIDTH(32), .DEPTH(D)) u_ring (
    .clk(clk), .we(cmd.r_we), .addr(r_addr), .wdata(el_r), .rdata(r_rdata)
  );

  stwss_ram #(.WIDTH(32), .DEPTH(D)) u_sorted (
    .clk(clk), .we(cmd.s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
  );

  assign ok = ({28'd0, st_r} < 32'(STAGES));
  assign has = ok && (n_cur != '0);

  assign st.bad      = !ok;
  assign st.query    = op_r;
  assign st.full     = (n_cur == CW'(WINDOW));
  assign st.rm_last  = (j_r == n_r - CW'(1));
  assign st.j_zero   = (j_r == '0);
  assign st.gt       = (s_rdata > el_r);
  assign st.found    = found_r;
  assign st.empty    = (n_cur == '0);
  assign st.q_last   = (qsel == 2'd2);
  assign st.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) begin
        wp[i]    <= '0;
        fill[i]  <= '0;
        total[i] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        wp[sidx] <= (wp[sidx] == WW'(WINDOW - 1)) ? '0 : wp[sidx] + WW'(1);
        if (fill[sidx] != CW'(WINDOW)) begin
          fill[sidx] <= fill[sidx] + CW'(1);
        end
        if (total[sidx] != '1) begin
          total[sidx] <= total[sidx] + 32'd1;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r <= in_op;
      st_r <= in_data[3:0];
      el_r <= in_data[35:4];
      qsel <= 2'd0;
    end
    if (cmd.commit) begin
      last[sidx] <= el_r;
    end
    if (cmd.n_load) begin
      n_r <= n_cur;
      j_r <= n_cur;
    end
    if (cmd.take_old) begin
      old_r   <= r_rdata;
      j_r     <= '0;
      found_r <= 1'b0;
    end
    if (cmd.rm_ev && !found_r && s_rdata == old_r) begin
      found_r <= 1'b1;
    end
    if (cmd.j_inc) begin
      j_r <= j_r + CW'(1);
    end
    if (cmd.j_dec) begin
      j_r <= jm1;
    end
    if (cmd.q_take) begin
      case (qsel)
        2'd0:    mn_r <= s_rdata;
        2'd1:    mx_r <= s_rdata;
        default: md_r <= s_rdata;
      endcase
      qsel <= qsel + 2'd1;
    end
    if (cmd.out_load) begin
      out_ok <= ok;
      if (has) begin
        out_data <= {md_r, mx_r, mn_r, last[sidx], total[sidx], 7'(n_cur)};
      end else begin
        out_data <= '0;
      end
    end
  end

endmodule

/* rtl/stwss_checker.sv */
// Port-level checker for the timing window statistics core, with its bind.
`timescale 1ns / 1ps
module stwss_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [167:0] m_tdata,
  input logic         m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item dropped while stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("invalid stage item carries data");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6:0] == 7'd0 |-> m_tdata[166:7] == '0)
    else $error("empty stage item carries data");

  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6:0] != 7'd0 |->
      m_tdata[102:71] <= m_tdata[166:135] && m_tdata[166:135] <= m_tdata[134:103])
    else $error("median outside min and max");

endmodule

bind stage_timing_window_stats_core stwss_checker u_chk (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser)
);

/* test/stage_timing_window_stats_core_tb.sv */
// Testbench for the per-stage timing window statistics monitor with a stream driver and monitor.
`timescale 1ns / 1ps
module stage_timing_window_stats_core_tb;
  import stwss_pkg::*;

  localparam int NST = STAGES_DEF;
  localparam int WIN = WINDOW_DEF;
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic        op;
    logic [3:0]  stage;
    logic [31:0] elapsed;
  } req_t;

  typedef struct packed {
    logic        stage_ok;
    logic [6:0]  window_count;
    logic [31:0] lifetime_count;
    logic [31:0] last_sample;
    logic [31:0] min_sample;
    logic [31:0] max_sample;
    logic [31:0] median_sample;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [39:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [167:0] m_tdata;
  logic m_tuser;

  stage_timing_window_stats_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  req_t pending_reqs[$];
  stats_t expected_stats[$];
  logic [31:0] ring[NST][WIN];
  int unsigned wr_ptr[NST];
  int unsigned fill[NST];
  logic [31:0] lifetime[NST];
  int errors = 0;
  longint cycles = 0;
  bit quiet = 1'b0;
  bit stim_done = 1'b0;
  bit in_taken = 1'b0;
  int src_gap = 0;
  int snk_gap = 0;

  initial forever #4 clk = ~clk;

  function automatic stats_t step_stage(req_t r);
    stats_t s;
    logic [31:0] sorted[$];
    int unsigned st, n, last;
    s = '0;
    st = r.stage;
    if (st >= NST) return s;
    if (r.op == OP_RECORD) begin
      ring[st][wr_ptr[st]] = r.elapsed;
      wr_ptr[st] = (wr_ptr[st] + 1) % WIN;
      if (fill[st] < WIN) fill[st]++;
      if (lifetime[st] != 32'hFFFF_FFFF) lifetime[st]++;
    end
    s.stage_ok = 1'b1;
    n = fill[st];
    if (n == 0) return s;
    for (int i = 0; i < n; i++) sorted.push_back(ring[st][i]);
    sorted.sort();
    last = (wr_ptr[st] == 0) ? WIN - 1 : wr_ptr[st] - 1;
    s.window_count = n[6:0];
    s.lifetime_count = lifetime[st];
    s.last_sample = ring[st][last];
    s.min_sample = sorted[0];
    s.max_sample = sorted[n - 1];
    s.median_sample = sorted[n / 2];
    return s;
  endfunction

  function automatic logic [31:0] rand_elapsed();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(logic op, logic [3:0] stage, logic [31:0] el);
    req_t r;
    r.op = op;
    r.stage = stage;
    r.elapsed = el;
    pending_reqs.push_back(r);
  endtask

  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && !in_taken) begin
      end else if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        src_gap = $urandom_range(1, 13) - 1;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_t r;
        r = pending_reqs.pop_front();
        expected_stats.push_back(step_stage(r));
        s_tvalid <= 1'b1;
        s_tuser <= r.op;
        s_tdata <= {4'b0, r.elapsed, r.stage};
      end else begin
        s_tvalid <= 1'b0;
      end
      in_taken = 1'b0;
      if (snk_gap > 0) begin
        snk_gap--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        snk_gap = $urandom_range(1, 13) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
    if (!rst && s_tvalid && s_tready) begin
      in_taken = 1'b1;
    end
    if (!rst && m_tvalid && m_tready) begin
      stats_t got, exp_s;
      got = {m_tuser, m_tdata[6:0], m_tdata[38:7], m_tdata[70:39], m_tdata[102:71],
             m_tdata[134:103], m_tdata[166:135]};
      if (expected_stats.size() == 0) begin
        $error("result with no expectation: %h", got);
        errors++;
      end else begin
        exp_s = expected_stats.pop_front();
        if (got.stage_ok !== exp_s.stage_ok) begin
          $error("stage_ok exp %0d got %0d", exp_s.stage_ok, got.stage_ok); errors++;
        end
        if (got.window_count !== exp_s.window_count) begin
          $error("window_count exp %0d got %0d", exp_s.window_count, got.window_count);
          errors++;
        end
        if (got.lifetime_count !== exp_s.lifetime_count) begin
          $error("lifetime_count exp %0d got %0d", exp_s.lifetime_count,
                 got.lifetime_count);
          errors++;
        end
        if (got.last_sample !== exp_s.last_sample) begin
          $error("last_sample exp %0d got %0d", exp_s.last_sample, got.last_sample);
          errors++;
        end
        if (got.min_sample !== exp_s.min_sample) begin
          $error("min_sample exp %0d got %0d", exp_s.min_sample, got.min_sample); errors++;
        end
        if (got.max_sample !== exp_s.max_sample) begin
          $error("max_sample exp %0d got %0d", exp_s.max_sample, got.max_sample); errors++;
        end
        if (got.median_sample !== exp_s.median_sample) begin
          $error("median_sample exp %0d got %0d", exp_s.median_sample, got.median_sample);
          errors++;
        end
      end
    end
    if (stim_done && pending_reqs.size() == 0 && expected_stats.size() == 0
        && !s_tvalid) begin
      stim_done = 1'b0;
      repeat (300) @(posedge clk);
      if (errors == 0 && expected_stats.size() == 0) begin
        $display("PASSED: all results match");
      end else begin
        $display("FAILED: results differ");
      end
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NST; i++) begin
      wr_ptr[i] = 0;
      fill[i] = 0;
      lifetime[i] = '0;
    end
    add_req(OP_QUERY, 4'd0, 32'h0);
    add_req(OP_QUERY, 4'd15, 32'hFFFF_FFFF);
    add_req(OP_RECORD, 4'd15, 32'h1234_5678);
    add_req(OP_RECORD, 4'd9, 32'hFFFF_FFFF);
    add_req(OP_RECORD, 4'd0, 32'hFFFF_FFFF);
    add_req(OP_RECORD, 4'd0, 32'h0);
    add_req(OP_RECORD, 4'd0, 32'h5555_5555);
    add_req(OP_QUERY, 4'd0, 32'hAAAA_AAAA);
    add_req(OP_RECORD, 4'd8, 32'h0);
    add_req(OP_RECORD, 4'd8, 32'hFFFF_FFFF);
    add_req(OP_QUERY, 4'd8, 32'h0);
    add_req(OP_QUERY, 4'd7, 32'h0);
    for (int i = 0; i < 70; i++) add_req(OP_RECORD, 4'd1, 32'(70 - i));
    add_req(OP_QUERY, 4'd1, 32'h0);
    for (int i = 0; i < 800; i++) begin
      int k;
      logic [3:0] st;
      k = $urandom_range(0, 9);
      st = (k == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, NST - 1));
      add_req((k < 8) ? OP_RECORD : OP_QUERY, st, rand_elapsed());
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() < 100);
    quiet = 1'b1;
    wait (pending_reqs.size() == 0);
    stim_done = 1'b1;
  end

endmodule

/* filelist.f */
rtl/stwss_pkg.sv
rtl/stwss_ram.sv
rtl/stwss_ctrl.sv
rtl/stwss_dp.sv
rtl/stage_timing_window_stats_core.sv
rtl/stwss_checker.sv
test/stage_timing_window_stats_core_tb.sv
